// File: hdl/dsd_pkg.sv
package dsd_pkg;

  localparam logic [2:0] ST_SAMPLE  = 3'd0;
  localparam logic [2:0] ST_SIZE    = 3'd1;
  localparam logic [2:0] ST_TYPE    = 3'd2;
  localparam logic [2:0] ST_VERSION = 3'd3;
  localparam logic [2:0] ST_RATE    = 3'd4;
  localparam logic [2:0] ST_CHAN    = 3'd5;
  localparam logic [2:0] ST_MISSING = 3'd6;
  localparam logic [2:0] ST_TRUNC   = 3'd7;

  localparam logic [31:0] TAG_FRM8 = 32'h384d5246;
  localparam logic [31:0] TAG_FVER = 32'h52455646;
  localparam logic [31:0] TAG_PROP = 32'h504f5250;
  localparam logic [31:0] TAG_FS   = 32'h20205346;
  localparam logic [31:0] TAG_SND  = 32'h20444e53;
  localparam logic [31:0] TAG_CHNL = 32'h4c4e4843;
  localparam logic [31:0] TAG_CMPR = 32'h52504d43;
  localparam logic [31:0] TAG_DSD  = 32'h20445344;
  localparam logic [31:0] RATE_DSD64 = 32'd2822400;
  localparam logic [63:0] MAX_SIZE = 64'h7fffffff;

  localparam int QUEUE_DEPTH = 4;

  // Work handed from the parser to the packer.
  typedef struct packed {
    logic       is_err;
    logic [2:0] status;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic       parity;
    logic       last;
  } dsd_cmd_t;

endpackage

// File: hdl/dsd_if.sv
interface dsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;
  modport source (output valid, data_byte, end_of_input, input ready);
  modport sink (input valid, data_byte, end_of_input, output ready);
endinterface

interface dsd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] sample_word;
  logic        channel;
  logic        last;
  modport source (output valid, status, sample_word, channel, last, input ready);
  modport sink (input valid, status, sample_word, channel, last, output ready);
endinterface

// File: hdl/dsd_parser.sv
module dsd_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [7:0]         b,
  input  logic               eoi,
  output logic               cmd_valid,
  output dsd_pkg::dsd_cmd_t  cmd
);
  import dsd_pkg::*;

  localparam logic [3:0] PH_ID = 4'd0, PH_SIZE = 4'd1, PH_FORM = 4'd2, PH_VER = 4'd3,
    PH_PROP = 4'd4, PH_RATE = 4'd5, PH_CHAN = 4'd6, PH_CMPR = 4'd7, PH_SKIP = 4'd8,
    PH_DATA = 4'd9, PH_IDLE = 4'd10;

  logic [3:0]  phase, phase_next;
  logic [3:0]  idx, idx_next;
  logic [31:0] tag, tag_next;
  logic [63:0] len, len_next;
  logic [31:0] fv, fv_next;
  logic [31:0] skip, skip_next;
  logic [6:0]  seen, seen_next;
  logic [28:0] frames, frames_next;
  logic        parity, parity_next;
  logic [23:0] held, held_next;
  logic [31:0] le, be;
  logic [63:0] ln;
  logic [2:0]  err;
  logic        big, frame_done;
  logic [28:0] fdec;

  assign le = {b, fv[31:8]};
  assign be = {fv[23:0], b};
  assign ln = {len[55:0], b};
  assign big = (len > MAX_SIZE);
  assign fdec = frames - 29'd1;

  // Decode one beat of the file.
  always_comb begin
    phase_next = phase; idx_next = idx; tag_next = tag; len_next = len; fv_next = fv;
    skip_next = skip; seen_next = seen; frames_next = frames; parity_next = parity;
    held_next = held; err = ST_SAMPLE; frame_done = 1'b0;
    unique case (phase)
      PH_ID: begin
        tag_next = {b, tag[31:8]};
        idx_next = idx + 4'd1;
        if (idx == 4'd3) begin
          idx_next = '0; len_next = '0; phase_next = PH_SIZE;
        end
      end
      PH_SIZE: begin
        len_next = ln;
        idx_next = idx + 4'd1;
        if (idx == 4'd7) begin
          idx_next = '0; fv_next = '0;
          priority case (tag)
            TAG_FRM8: phase_next = PH_FORM;
            TAG_FVER: phase_next = PH_VER;
            TAG_PROP: phase_next = PH_PROP;
            TAG_FS:   phase_next = PH_RATE;
            TAG_CHNL: phase_next = PH_CHAN;
            TAG_CMPR: phase_next = PH_CMPR;
            TAG_DSD: begin
              if (ln == 64'd0 || ln > MAX_SIZE) err = ST_SIZE;
              else if (seen[5:0] != 6'h3f) err = ST_MISSING;
              else begin
                seen_next = seen | 7'h40;
                frames_next = ln[30:2];
                parity_next = 1'b0;
                phase_next = (ln[30:2] != '0) ? PH_DATA : PH_IDLE;
              end
            end
            default: begin
              if (ln == 64'd0 || ln > MAX_SIZE) err = ST_SIZE;
              else begin
                skip_next = ln[31:0] + {31'd0, ln[0]};
                phase_next = PH_SKIP;
              end
            end
          endcase
        end
      end
      PH_FORM, PH_PROP, PH_CMPR: begin
        fv_next = le;
        idx_next = idx + 4'd1;
        if (idx == 4'd3) begin
          idx_next = '0;
          if (phase == PH_FORM) begin
            if (big) err = ST_SIZE;
            else if (le != TAG_DSD) err = ST_TYPE;
            else begin
              seen_next = (len != '0) ? (seen | 7'h01) : (seen & 7'h7e);
              phase_next = PH_ID;
            end
          end else if (phase == PH_PROP) begin
            if (len < 64'd4) err = ST_SIZE;
            else if (le != TAG_SND) err = ST_TYPE;
            else begin
              seen_next = seen | 7'h04; phase_next = PH_ID;
            end
          end else begin
            if (len < 64'd5 || big) err = ST_SIZE;
            else if (le != TAG_DSD) err = ST_TYPE;
            else begin
              seen_next = seen | 7'h20;
              skip_next = len[31:0] - 32'd4 + {31'd0, len[0]};
              phase_next = PH_SKIP;
            end
          end
        end
      end
      PH_VER, PH_RATE: begin
        fv_next = be;
        idx_next = idx + 4'd1;
        if (idx == 4'd3) begin
          idx_next = '0;
          if (len != 64'd4) err = ST_SIZE;
          else if (phase == PH_VER) begin
            if (be[31:24] != 8'h01) err = ST_VERSION;
            else begin
              seen_next = seen | 7'h02; phase_next = PH_ID;
            end
          end else begin
            if (be != RATE_DSD64) err = ST_RATE;
            else begin
              seen_next = seen | 7'h08; phase_next = PH_ID;
            end
          end
        end
      end
      PH_CHAN: begin
        fv_next = be;
        idx_next = idx + 4'd1;
        if (idx == 4'd1) begin
          idx_next = '0;
          if (len < 64'd6 || big) err = ST_SIZE;
          else if (be[15:0] != 16'd2) err = ST_CHAN;
          else begin
            seen_next = seen | 7'h10;
            skip_next = len[31:0] - 32'd2 + {31'd0, len[0]};
            phase_next = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        // skip counts are always nonzero on entry
        skip_next = skip - 32'd1;
        if (skip == 32'd1) phase_next = PH_ID;
      end
      PH_DATA: begin
        unique case (idx[1:0])
          2'd0: held_next = {16'd0, b};
          2'd1: held_next[15:8] = b;
          2'd2: held_next[23:16] = b;
          default: held_next = held;
        endcase
        idx_next = idx + 4'd1;
        if (idx == 4'd3) begin
          idx_next = '0;
          frames_next = fdec;
          frame_done = 1'b1;
          parity_next = ~parity;
          if (fdec == '0) phase_next = PH_IDLE;
        end
      end
      default: ;
    endcase
    if (err != ST_SAMPLE) phase_next = PH_IDLE;
  end

  // Form the command for the packer.
  always_comb begin
    cmd = '0;
    cmd.b0 = held[7:0]; cmd.b1 = held[15:8]; cmd.b2 = held[23:16]; cmd.b3 = b;
    cmd.parity = parity; cmd.last = (fdec == '0);
    cmd_valid = fire & frame_done;
    if (err != ST_SAMPLE) begin
      cmd.is_err = 1'b1; cmd.status = err; cmd_valid = fire;
    end
    if (eoi) begin
      cmd_valid = 1'b0;
      if (phase_next != PH_IDLE) begin
        cmd_valid = fire;
        cmd.is_err = 1'b1;
        cmd.status = (phase_next == PH_ID && idx_next == '0 && phase != PH_DATA)
                   ? ST_MISSING : ST_TRUNC;
      end else if (err != ST_SAMPLE) begin
        cmd_valid = fire;
      end else if (frame_done) begin
        cmd_valid = fire;
      end
    end
  end

  // Advance parse state on each accepted beat; rearm at end of file.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_ID; idx <= '0; tag <= '0; len <= '0; fv <= '0; skip <= '0;
      seen <= '0; frames <= '0; parity <= 1'b0;
    end else if (fire) begin
      held <= held_next;
      if (eoi) begin
        phase <= PH_ID; idx <= '0; tag <= '0; len <= '0; fv <= '0; skip <= '0;
        seen <= '0; frames <= '0; parity <= 1'b0;
      end else begin
        phase <= phase_next; idx <= idx_next; tag <= tag_next; len <= len_next;
        fv <= fv_next; skip <= skip_next; seen <= seen_next;
        frames <= frames_next; parity <= parity_next;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd_valid |-> fire)
    else $error("command without beat");
  assert property (@(posedge clk) disable iff (rst) (phase == PH_SKIP) |-> (skip != '0))
    else $error("skip count empty in skip phase");
  assert property (@(posedge clk) disable iff (rst) (phase == PH_DATA) |-> (frames != '0))
    else $error("no frames left in data phase");
endmodule

// File: hdl/dsd_packer.sv
module dsd_packer #(
  parameter int Depth = dsd_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               mode,
  input  logic               cmd_valid,
  input  dsd_pkg::dsd_cmd_t  cmd,
  output logic               space_ok,
  dsd_out_if.source          out
);
  import dsd_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  dsd_cmd_t        q [Depth];
  logic [AW-1:0]   wp, rp;
  logic [AW:0]     cnt;
  logic            half;
  logic            pop, push;
  dsd_cmd_t        h;
  logic [23:0]     w24;
  logic [7:0]      mk;

  assign h = q[rp];
  // Keep two free slots so a beat in flight always fits.
  assign space_ok = (cnt <= AW'(Depth - 2));
  assign push = cmd_valid;
  assign out.valid = (cnt != '0);
  assign pop = out.valid & out.ready & (h.is_err | half);

  assign mk = h.parity ? 8'hfa : 8'h05;
  assign w24 = half ? {mk, h.b1, h.b3} : {mk, h.b0, h.b2};
  assign out.status = h.is_err ? h.status : ST_SAMPLE;
  assign out.sample_word = h.is_err ? 32'd0 : (mode ? {w24, 8'd0} : {8'd0, w24});
  assign out.channel = ~h.is_err & half;
  assign out.last = ~h.is_err & half & h.last;

  // Hold commands in a small queue; emit left then right per frame, or a single beat for an error.
  always_ff @(posedge clk) begin
    if (push) q[wp] <= cmd;
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0; half <= 1'b0;
    end else begin
      if (push) wp <= (wp == AW'(Depth - 1)) ? '0 : wp + 1'b1;
      if (pop) rp <= (rp == AW'(Depth - 1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
      if (out.valid & out.ready) half <= h.is_err ? 1'b0 : ~half;
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= (AW+1)'(Depth))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) (cnt == '0) |-> !half)
    else $error("half set on empty queue");
  assert property (@(posedge clk) disable iff (rst) push |-> (cnt != (AW+1)'(Depth)))
    else $error("push into full queue");
endmodule

// File: hdl/dsdiff_to_dop_stream_converter_core.sv
// DSDIFF to DoP stream converter.
// in: one DSDIFF file byte per beat (data_byte), end_of_input marks the
//   file's last byte; the parser then rearms for the next file.
// out: result beats. Each 4-byte stereo frame of sound data gives two
//   beats, left then right, status 0 and a DoP word with 05/FA markers;
//   last flags the right word of the final frame. A format error or an
//   early end gives a single beat with a nonzero status and zero word.
// container_mode (cfg_we/cfg_data): 0 packs 24-bit words, 1 left-aligns
//   them in 32 bits; write it only between files.
// Throughput: one input byte per cycle while the command queue has room;
//   a frame's four bytes yield two output beats, so the output side sets no limit at full rate.
// A result is queued with the byte that completes it, behind any beats still waiting.
// The parser feeds a four-entry command queue; input ready drops when the
//   queue has fewer than two free slots, so a stalled receiver backs up
//   into the byte stream without losing anything.
// Reset clears parse state, the queue and container_mode.
module dsdiff_to_dop_stream_converter_core #(
  parameter int QueueDepth = dsd_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_data,
  dsd_in_if.sink    in,
  dsd_out_if.source out
);
  import dsd_pkg::*;

  logic      mode;
  logic      space_ok;
  logic      fire;
  logic      cmd_valid;
  dsd_cmd_t  cmd;

  assign in.ready = space_ok;
  assign fire = in.valid & in.ready;

  // Hold the container mode register.
  always_ff @(posedge clk) begin
    if (rst) mode <= 1'b0;
    else if (cfg_we) mode <= cfg_data;
  end

  dsd_parser u_parser (
    .clk(clk), .rst(rst), .fire(fire), .b(in.data_byte), .eoi(in.end_of_input),
    .cmd_valid(cmd_valid), .cmd(cmd)
  );

  dsd_packer #(.Depth(QueueDepth)) u_packer (
    .clk(clk), .rst(rst), .mode(mode), .cmd_valid(cmd_valid), .cmd(cmd),
    .space_ok(space_ok), .out(out)
  );
endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import dsd_pkg::*;

  typedef enum logic [3:0] {
    P_ID, P_SIZE, P_FORM, P_VER, P_PROP, P_RATE, P_CHAN, P_CMPR, P_SKIP, P_DATA, P_IDLE
  } parse_e;

  typedef enum int {
    K_GOOD, K_FORM0, K_FORMTYPE, K_FORMHUGE, K_VER, K_VERLEN, K_RATE, K_CHAN,
    K_CHNLHUGE, K_CMPRTYPE, K_CMPRSHORT, K_PROPSHORT, K_PROPTYPE, K_MISSING,
    K_SND0, K_SNDHUGE, K_SNDTINY, K_UNKHUGE, K_UNK0, K_CUT, K_CUTEDGE, K_ERREOI,
    K_FLIP, K_NOISE, K_COUNT
  } file_kind_e;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] word;
    logic        channel;
    logic        last;
  } dop_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
  } file_byte_t;

  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic cfg_data;

  dsd_in_if  in_ch ();
  dsd_out_if out_ch ();

  dsdiff_to_dop_stream_converter_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in(in_ch),
    .out(out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Parser mirror state
  parse_e      ph = P_ID;
  int unsigned bidx = 0;
  logic [31:0] tag = '0;
  logic [63:0] clen = '0;
  logic [31:0] fval = '0;
  logic [31:0] skip_left = '0;
  logic [6:0]  seen = '0;
  logic [31:0] frames = '0;
  logic        par = 1'b0;
  logic [23:0] held = '0;
  logic        cmode = 1'b0;

  dop_beat_t  dop_q[$];
  file_byte_t pending[$];
  logic [7:0] fileb[$];

  int err_cnt = 0;
  int sent = 0;
  int cyc = 0;
  int gap = 0;
  int owait = 0;
  logic in_acc = 1'b0;
  logic out_acc = 1'b0;
  logic in_busy = 1'b1;
  logic out_busy = 1'b1;
  logic hold = 1'b0;
  logic stall_go = 1'b0;

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic logic [31:0] dop_word(input logic [7:0] older, input logic [7:0] newer);
    logic [31:0] w;
    w = {8'h00, (par ? 8'hfa : 8'h05), older, newer};
    return cmode ? (w << 8) : w;
  endfunction

  task automatic begin_skip(input logic [31:0] count);
    skip_left = count;
    ph = (count == 0) ? P_ID : P_SKIP;
  endtask

  task automatic rearm();
    ph = P_ID;
    bidx = 0;
    tag = '0;
    clen = '0;
    fval = '0;
    skip_left = '0;
    seen = '0;
    frames = '0;
    par = 1'b0;
    held = '0;
  endtask

  // Advance the parser mirror by one accepted byte and queue what it yields
  task automatic absorb_byte(input logic [7:0] b, input logic eoi);
    logic [31:0] le, be;
    logic [63:0] len;
    logic [2:0]  err;
    logic        fin;
    dop_beat_t   got[$];
    le = {b, fval[31:8]};
    be = {fval[23:0], b};
    len = clen;
    err = ST_SAMPLE;
    case (ph)
      P_ID: begin
        tag = {b, tag[31:8]};
        bidx++;
        if (bidx >= 4) begin
          bidx = 0;
          clen = '0;
          ph = P_SIZE;
        end
      end
      P_SIZE: begin
        clen = {clen[55:0], b};
        len = clen;
        bidx++;
        if (bidx >= 8) begin
          bidx = 0;
          fval = '0;
          case (tag)
            TAG_FRM8: ph = P_FORM;
            TAG_FVER: ph = P_VER;
            TAG_PROP: ph = P_PROP;
            TAG_FS:   ph = P_RATE;
            TAG_CHNL: ph = P_CHAN;
            TAG_CMPR: ph = P_CMPR;
            TAG_DSD: begin
              if (len == 0 || len > MAX_SIZE) err = ST_SIZE;
              else if (seen[5:0] != 6'h3f) err = ST_MISSING;
              else begin
                seen[6] = 1'b1;
                frames = 32'(len >> 2);
                par = 1'b0;
                ph = (frames != 0) ? P_DATA : P_IDLE;
              end
            end
            default: begin
              if (len == 0 || len > MAX_SIZE) err = ST_SIZE;
              else begin_skip(32'((len + 1) & ~64'd1));
            end
          endcase
        end
      end
      P_FORM, P_PROP, P_CMPR: begin
        fval = le;
        bidx++;
        if (bidx >= 4) begin
          bidx = 0;
          if (ph == P_FORM) begin
            if (len > MAX_SIZE) err = ST_SIZE;
            else if (le != TAG_DSD) err = ST_TYPE;
            else begin
              seen[0] = (len != 0);
              ph = P_ID;
            end
          end else if (ph == P_PROP) begin
            if (len < 4) err = ST_SIZE;
            else if (le != TAG_SND) err = ST_TYPE;
            else begin
              seen[2] = 1'b1;
              ph = P_ID;
            end
          end else begin
            if (len < 5 || len > MAX_SIZE) err = ST_SIZE;
            else if (le != TAG_DSD) err = ST_TYPE;
            else begin
              seen[5] = 1'b1;
              begin_skip(32'(len - 4 + {63'd0, len[0]}));
            end
          end
        end
      end
      P_VER, P_RATE: begin
        fval = be;
        bidx++;
        if (bidx >= 4) begin
          bidx = 0;
          if (len != 4) err = ST_SIZE;
          else if (ph == P_VER) begin
            if (be[31:24] != 8'h01) err = ST_VERSION;
            else begin
              seen[1] = 1'b1;
              ph = P_ID;
            end
          end else begin
            if (be != RATE_DSD64) err = ST_RATE;
            else begin
              seen[3] = 1'b1;
              ph = P_ID;
            end
          end
        end
      end
      P_CHAN: begin
        fval = be;
        bidx++;
        if (bidx >= 2) begin
          bidx = 0;
          if (len < 6 || len > MAX_SIZE) err = ST_SIZE;
          else if (be[15:0] != 16'd2) err = ST_CHAN;
          else begin
            seen[4] = 1'b1;
            begin_skip(32'(len - 2 + {63'd0, len[0]}));
          end
        end
      end
      P_SKIP: begin
        if (skip_left > 0) skip_left--;
        if (skip_left == 0) ph = P_ID;
      end
      P_DATA: begin
        if (bidx == 0) held = '0;
        if (bidx < 3) begin
          held = held | (24'(b) << (8 * bidx));
          bidx++;
        end else begin
          bidx = 0;
          frames = (frames - 1) & 32'h1fffffff;
          fin = (frames == 0);
          got.push_back('{ST_SAMPLE, dop_word(held[7:0], held[23:16]), 1'b0, 1'b0});
          got.push_back('{ST_SAMPLE, dop_word(held[15:8], b), 1'b1, fin});
          par = ~par;
          if (fin) ph = P_IDLE;
        end
      end
      default: ;
    endcase

    // An error replaces anything this byte produced
    if (err != ST_SAMPLE) begin
      got.delete();
      got.push_back('{err, 32'd0, 1'b0, 1'b0});
      ph = P_IDLE;
    end

    // End of file: flag an early end, then rearm
    if (eoi) begin
      if (ph != P_IDLE) begin
        got.delete();
        got.push_back('{((ph == P_ID && bidx == 0) ? ST_MISSING : ST_TRUNC),
                        32'd0, 1'b0, 1'b0});
      end
      rearm();
    end

    foreach (got[i]) dop_q.push_back(got[i]);
  endtask

  // Track accepted bytes and register writes
  always @(posedge clk) begin
    in_acc <= !rst && in_ch.valid && in_ch.ready;
    if (!rst && cfg_we) cmode = cfg_data;
    if (!rst && in_ch.valid && in_ch.ready) absorb_byte(in_ch.data_byte, in_ch.end_of_input);
  end

  // Byte driver: hold a beat until taken, then advance after a random gap
  always @(negedge clk) begin
    file_byte_t it;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_acc) begin
      if (gap > 0) begin
        gap--;
        in_ch.valid <= 1'b0;
      end else if (pending.size() > 0) begin
        it = pending.pop_front();
        in_ch.data_byte <= it.data;
        in_ch.end_of_input <= it.eoi;
        in_ch.valid <= 1'b1;
        if ($urandom_range(0, 149) == 0) in_busy = ~in_busy;
        // Keep bytes coming at full rate while the receiver is held off
        gap = (in_busy && !hold) ? $urandom_range(0, 18) : 0;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor: compare each beat with the oldest prediction
  always @(posedge clk) begin
    dop_beat_t want;
    out_acc <= !rst && out_ch.valid && out_ch.ready;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (dop_q.size() == 0) begin
        report($sformatf("unexpected beat status=%0d word=%h ch=%0d last=%0d",
                         out_ch.status, out_ch.sample_word, out_ch.channel, out_ch.last));
      end else begin
        want = dop_q.pop_front();
        if (out_ch.status !== want.status)
          report($sformatf("status %0d, want %0d", out_ch.status, want.status));
        if (out_ch.sample_word !== want.word)
          report($sformatf("sample_word %h, want %h", out_ch.sample_word, want.word));
        if (out_ch.channel !== want.channel)
          report($sformatf("channel %0d, want %0d", out_ch.channel, want.channel));
        if (out_ch.last !== want.last)
          report($sformatf("last %0d, want %0d", out_ch.last, want.last));
      end
    end
  end

  // Receiver: random wait after each beat, plus the long hold
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_acc) begin
        if ($urandom_range(0, 149) == 0) out_busy = ~out_busy;
        owait = out_busy ? $urandom_range(0, 18) : 0;
      end
      if (hold) begin
        out_ch.ready <= 1'b0;
      end else if (owait > 0) begin
        owait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Long receiver hold while bytes keep coming
  initial begin
    wait (stall_go);
    repeat (40) @(posedge clk);
    hold = 1'b1;
    repeat (300) @(posedge clk);
    hold = 1'b0;
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > LIMIT) begin
      $display("dsdiff_to_dop_stream_converter_core test failed");
      $finish;
    end
  end

  task automatic put_be(input logic [63:0] x, input int n);
    for (int i = n - 1; i >= 0; i--) fileb.push_back(x[8*i +: 8]);
  endtask

  task automatic put_le(input logic [31:0] x);
    for (int i = 0; i < 4; i++) fileb.push_back(x[8*i +: 8]);
  endtask

  task automatic put_rand(input int n);
    repeat (n) fileb.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic send_file();
    foreach (fileb[i]) pending.push_back('{fileb[i], (i == fileb.size() - 1)});
    sent += fileb.size();
  endtask

  // Build one file of the given kind and queue its bytes
  task automatic make_file(input file_kind_e k);
    int order[9];
    int ends[$];
    int n, j, tmp, cut, fs_end, pos;
    logic [63:0] form_len, ver_len, prop_len, chn_len, cmpr_len, unk_len, snd_len;
    logic [31:0] ver, prop_type, form_type, rate, cmpr_type;
    logic [15:0] chn_cnt;
    fileb.delete();
    fs_end = 0;
    if (k == K_NOISE) begin
      put_rand($urandom_range(1, 30));
      send_file();
      return;
    end
    form_len = $urandom_range(1, 5000);
    form_type = TAG_DSD;
    ver_len = 4;
    ver = {8'h01, 24'($urandom)};
    prop_len = $urandom_range(4, 3000);
    prop_type = TAG_SND;
    rate = RATE_DSD64;
    chn_len = $urandom_range(6, 12);
    chn_cnt = 16'd2;
    cmpr_len = $urandom_range(5, 14);
    cmpr_type = TAG_DSD;
    unk_len = $urandom_range(1, 9);
    snd_len = 4 * (($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12));
    if ($urandom_range(0, 3) == 0) snd_len += $urandom_range(1, 3);
    case (k)
      K_FORM0:     form_len = 0;
      K_FORMTYPE:  form_type = $urandom;
      K_FORMHUGE:  form_len = 64'h80000000 + $urandom_range(0, 255);
      K_VER:       ver[31:24] = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(2, 255));
      K_VERLEN:    ver_len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(5, 9);
      K_RATE, K_ERREOI: rate = $urandom;
      K_CHAN:      chn_cnt = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 1))
                                                         : 16'($urandom_range(3, 65535));
      K_CHNLHUGE:  chn_len = ($urandom_range(0, 1) == 0) ? 64'hffffffffffffffff : 64'h80000000;
      K_CMPRTYPE:  cmpr_type = $urandom;
      K_CMPRSHORT: cmpr_len = $urandom_range(0, 4);
      K_PROPSHORT: prop_len = $urandom_range(0, 3);
      K_PROPTYPE:  prop_type = $urandom;
      K_SND0:      snd_len = 0;
      K_SNDHUGE:   snd_len = {32'($urandom), 32'($urandom)} | 64'h80000000;
      K_SNDTINY:   snd_len = $urandom_range(1, 3);
      K_UNKHUGE:   unk_len = 64'h100000000;
      K_UNK0:      unk_len = 0;
      default: ;
    endcase

    // Header chunks in shuffled order, with unknown chunks mixed in at times
    n = (k == K_UNKHUGE || k == K_UNK0) ? 7 + $urandom_range(0, 1) : 6 + $urandom_range(0, 2);
    for (int i = 0; i < 9; i++) order[i] = (i < 6) ? i : 6;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    if (k == K_MISSING) begin
      tmp = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) if (order[i] == tmp) order[i] = 7;
    end
    for (int i = 0; i < n; i++) begin
      case (order[i])
        0: begin
          put_le(TAG_FRM8); put_be(form_len, 8); put_le(form_type);
        end
        1: begin
          put_le(TAG_FVER); put_be(ver_len, 8); put_be(64'(ver), 4);
        end
        2: begin
          put_le(TAG_PROP); put_be(prop_len, 8); put_le(prop_type);
        end
        3: begin
          put_le(TAG_FS); put_be(64'd4, 8); put_be(64'(rate), 4);
          fs_end = fileb.size();
        end
        4: begin
          put_le(TAG_CHNL); put_be(chn_len, 8); put_be(64'(chn_cnt), 2);
          if (chn_len >= 6 && chn_len <= 64) put_rand(int'(chn_len) - 2 + int'(chn_len[0]));
        end
        5: begin
          put_le(TAG_CMPR); put_be(cmpr_len, 8); put_le(cmpr_type);
          if (cmpr_len >= 4 && cmpr_len <= 64) put_rand(int'(cmpr_len) - 4 + int'(cmpr_len[0]));
        end
        6: begin
          put_le($urandom); put_be(unk_len, 8);
          if (unk_len <= 64) put_rand(int'((unk_len + 1) & ~64'd1));
        end
        default: ;
      endcase
      if (order[i] != 7) ends.push_back(fileb.size());
    end

    // Sound chunk, data and some trailing bytes
    put_le(TAG_DSD);
    put_be(snd_len, 8);
    if (snd_len <= 4096) begin
      put_rand(int'(snd_len));
      put_rand($urandom_range(0, 4));
    end

    case (k)
      K_CUT:      cut = $urandom_range(1, fileb.size());
      K_CUTEDGE:  cut = ends[$urandom_range(0, ends.size() - 1)];
      K_ERREOI:   cut = fs_end;
      default:    cut = fileb.size();
    endcase
    while (fileb.size() > cut) void'(fileb.pop_back());
    if (k == K_FLIP) begin
      pos = $urandom_range(0, fileb.size() - 1);
      fileb[pos] = fileb[pos] ^ 8'(1 << $urandom_range(0, 7));
    end
    send_file();
  endtask

  task automatic random_files(input int target);
    int goal;
    goal = sent + target;
    while (sent < goal) begin
      if ($urandom_range(0, 19) < 11) make_file(K_GOOD);
      else make_file(file_kind_e'($urandom_range(0, K_COUNT - 1)));
    end
  endtask

  // Wait until every byte is taken and every result has come back
  task automatic wait_idle();
    do @(posedge clk); while (pending.size() > 0 || in_ch.valid || dop_q.size() > 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input logic v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    cfg_we = 1'b0;
    cfg_data = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.end_of_input = 1'b0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Files in the 24-bit mode left by reset
    random_files(400);
    wait_idle();

    write_mode(1'b1);
    stall_go = 1'b1;
    random_files(400);
    wait_idle();

    write_mode(1'b0);
    random_files(350);
    wait_idle();

    repeat (20) @(posedge clk);
    if (err_cnt == 0 && dop_q.size() == 0) begin
      $display("dsdiff_to_dop_stream_converter_core test passed");
    end else begin
      $display("dsdiff_to_dop_stream_converter_core test failed");
    end
    $finish;
  end

endmodule
